/* rtl/ssq_pkg.sv */
// Package for the stable sorted priority queue.
// Field widths, command and status codes, the entry and result structs, and the
// priority function. No dependencies.
package ssq_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 16;
    localparam int AGI_W    = 8;
    localparam int KIND_W   = 2;
    localparam int PRIO_W   = 12;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Command codes; code 3 behaves as a query
    localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QRY = 2'd2;

    // Entry kinds; anything else uses the default factor
    localparam logic [KIND_W-1:0] KIND_AGILE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TANK  = 2'd1;

    localparam logic [3:0] FACTOR_AGILE = 4'd15;
    localparam logic [3:0] FACTOR_TANK  = 4'd8;
    localparam logic [3:0] FACTOR_OTHER = 4'd10;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic [ID_W-1:0]     front_id;
        logic [PRIO_W-1:0]   front_prio;
        logic [COUNT_W-1:0]  count;
        logic                empty;
        logic [STATUS_W-1:0] status;
    } t_result;

    // Priority in tenths: agility times 1.5, 0.8 or 1.0, zero when dead
    function automatic logic [PRIO_W-1:0] prio_tenths(
        input logic [AGI_W-1:0]  agility,
        input logic [KIND_W-1:0] kind,
        input logic              alive
    );
        logic [3:0]        factor;
        logic [PRIO_W-1:0] prod;
        case (kind)
            KIND_AGILE: factor = FACTOR_AGILE;
            KIND_TANK:  factor = FACTOR_TANK;
            default:    factor = FACTOR_OTHER;
        endcase
        prod = {{(PRIO_W-AGI_W){1'b0}}, agility} * {{(PRIO_W-4){1'b0}}, factor};
        return alive ? prod : '0;
    endfunction

endpackage

/* rtl/ssq_mem.sv */
// Entry store of the priority queue: one write port, one read port,
// registered read data. Depends on ssq_pkg for the entry struct.
module ssq_mem #(
    parameter int DEPTH = ssq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  ssq_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output ssq_pkg::t_entry o_rdata
);
    import ssq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ssq_ctrl.sv */
// Sequencer of the priority queue: circular store addressing, backward
// insertion shift, dequeue and front readout. Depends on ssq_pkg.
module ssq_ctrl #(
    parameter int DEPTH = ssq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ssq_pkg::CMD_W-1:0]    i_cmd,
    input  logic [ssq_pkg::ID_W-1:0]     i_entry_id,
    input  logic [ssq_pkg::AGI_W-1:0]    i_agility,
    input  logic [ssq_pkg::KIND_W-1:0]   i_kind,
    input  logic                         i_alive,
    // result handoff
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output ssq_pkg::t_result             o_res,
    // store ports
    output logic                         o_mem_we,
    output logic [AW-1:0]                o_mem_waddr,
    output ssq_pkg::t_entry              o_mem_wdata,
    output logic                         o_mem_re,
    output logic [AW-1:0]                o_mem_raddr,
    input  ssq_pkg::t_entry              i_mem_rdata
);
    import ssq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_A = (AW+1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [AW-1:0] ONE_A   = AW'(1);
    localparam logic [AW-1:0] TWO_A   = AW'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PUT,
        S_FRONT,
        S_RES
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_head, n_head;
    logic [AW-1:0]        r_k, n_k;       // slot being filled during the shift
    t_entry               r_new, n_new;
    logic [STATUS_W-1:0]  r_status, n_status;

    logic                 accept;
    logic [CW+COUNT_W-1:0] count_ext;

    // Logical slot to physical address, the front sits at r_head
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [AW-1:0] ofs);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= DEPTH_A) begin
            sum = sum - DEPTH_A;
        end
        return sum[AW-1:0];
    endfunction

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // Next state and store accesses
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_k         = r_k;
        n_new       = r_new;
        n_status    = r_status;
        o_mem_we    = 1'b0;
        o_mem_waddr = phys(r_head, r_k);
        o_mem_wdata = r_new;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_head;
        o_res_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_state  = S_FRONT;
                    case (i_cmd)
                        CMD_ENQ: begin
                            if (r_count == DEPTH_C) begin
                                n_status = ST_FULL;
                            end else begin
                                n_new.id   = i_entry_id;
                                n_new.prio = prio_tenths(i_agility, i_kind, i_alive);
                                n_count    = r_count + ONE_C;
                                n_k        = r_count[AW-1:0];
                                if (r_count == '0) begin
                                    n_state = S_PUT;
                                end else begin
                                    // fetch the current tail
                                    o_mem_re    = 1'b1;
                                    o_mem_raddr = phys(r_head, r_count[AW-1:0] - ONE_A);
                                    n_state     = S_SHIFT;
                                end
                            end
                        end
                        CMD_DEQ: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_head  = phys(r_head, ONE_A);
                                n_count = r_count - ONE_C;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // read data holds slot r_k-1; move it down or drop the new entry at r_k
            S_SHIFT: begin
                o_mem_we = 1'b1;
                if (i_mem_rdata.prio < r_new.prio) begin
                    o_mem_wdata = i_mem_rdata;
                    if (r_k == ONE_A) begin
                        n_state = S_PUT;
                    end else begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = phys(r_head, r_k - TWO_A);
                        n_k         = r_k - ONE_A;
                    end
                end else begin
                    n_state = S_FRONT;
                end
            end

            // new entry goes to the front slot
            S_PUT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_head;
                n_state     = S_FRONT;
            end

            S_FRONT: begin
                o_mem_re = 1'b1;
                n_state  = S_RES;
            end

            S_RES: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Result beat, front fields read as zero when empty
    assign count_ext = {{COUNT_W{1'b0}}, r_count};
    always_comb begin
        o_res.empty      = (r_count == '0);
        o_res.front_id   = o_res.empty ? '0 : i_mem_rdata.id;
        o_res.front_prio = o_res.empty ? '0 : i_mem_rdata.prio;
        o_res.count      = count_ext[COUNT_W-1:0];
        o_res.status     = r_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_head   <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_head   <= n_head;
        end
        r_k      <= n_k;
        r_new    <= n_new;
        r_status <= n_status;
    end

    // Held count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("held count above depth");

    // A write and a read never target the same slot in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && o_mem_re) |-> (o_mem_waddr != o_mem_raddr))
        else $error("read and write of one slot in the same cycle");

    // Count and head move only on an accepted command
    a_count_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && ((r_count != $past(r_count)) || (r_head != $past(r_head))))
        |-> $past(accept))
        else $error("queue state changed without a command");

    // Store is idle while a result waits
    a_res_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (!o_mem_we && !o_mem_re))
        else $error("store accessed while result pending");

endmodule

/* rtl/stable_sorted_priority_queue.sv */
// Stable sorted priority queue: max-priority queue of 16-bit handles, FIFO
// order among equal priorities, up to DEPTH entries.
//
// Command channel (i_valid/o_ready): one beat carries cmd, entry_id, agility,
// kind and alive. cmd 0 enqueues with priority in tenths (agility x15 agile,
// x8 tank, x10 other, 0 when dead), 1 dequeues the front, 2 or 3 only query.
// Result channel (o_valid/i_ready): exactly one beat per command with the
// front handle and priority (0 when empty), count, empty flag and status
// (0 ok, 1 dequeue on empty, 2 enqueue when full; neither changes anything).
//
// Entries live in a circular store with one read and one write port.
// Dequeue, query and a refused enqueue read the front (S_FRONT) and then
// offer the result (S_RES). An enqueue walks back from the tail moving one
// lower-priority entry per cycle past 0..DEPTH-1 entries, then writes the new
// entry, reads the front and offers the result.
// The next command is accepted once the previous result has been handed to
// the output register; that register lets one result wait while a new
// command is in progress, and a stalled receiver holds the pipeline after that.
// Reset empties the queue and drops any pending result; no clearing pass.
module stable_sorted_priority_queue #(
    parameter int DEPTH = ssq_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ssq_pkg::CMD_W-1:0]     i_cmd,
    input  logic [ssq_pkg::ID_W-1:0]      i_entry_id,
    input  logic [ssq_pkg::AGI_W-1:0]     i_agility,
    input  logic [ssq_pkg::KIND_W-1:0]    i_kind,
    input  logic                          i_alive,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ssq_pkg::ID_W-1:0]      o_front_id,
    output logic [ssq_pkg::PRIO_W-1:0]    o_front_priority,
    output logic [ssq_pkg::COUNT_W-1:0]   o_count,
    output logic                          o_empty_res,
    output logic [ssq_pkg::STATUS_W-1:0]  o_status
);
    import ssq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic            res_valid;
    logic            res_ready;
    t_result         res;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_entry          mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    t_entry          mem_rdata;

    logic            r_out_valid;
    t_result         r_out;

    ssq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_entry_id  (i_entry_id),
        .i_agility   (i_agility),
        .i_kind      (i_kind),
        .i_alive     (i_alive),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    ssq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register, refilled when empty or draining this cycle
    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_front_id       = r_out.front_id;
    assign o_front_priority = r_out.front_prio;
    assign o_count          = r_out.count;
    assign o_empty_res      = r_out.empty;
    assign o_status         = r_out.status;

endmodule
